@@ rtl/core/sspq_pkg.sv @@
package sspq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ID_W = 16;
  localparam int PRIO_W = 8;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell in the chain each cycle.
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t fresh;
  } cell_ctl_t;

endpackage

@@ rtl/core/sspq_cell.sv @@
module sspq_cell (
  input  logic               clk,
  input  sspq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  sspq_pkg::entry_t   left_ent,
  input  logic               left_take,
  input  sspq_pkg::entry_t   right_ent,
  output sspq_pkg::entry_t   ent,
  output logic               take
);
  import sspq_pkg::*;

  entry_t ent_next;

  // New entry lands at or before this slot: empty slot or strictly larger number.
  assign take = !occupied || (ent.prio > ctl.fresh.prio);

  always_comb begin
    ent_next = ent;
    if (ctl.insert && take) begin
      ent_next = left_take ? left_ent : ctl.fresh;
    end else if (ctl.pop) begin
      ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

@@ rtl/core/stable_sorted_priority_queue.sv @@
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   command, ticket_id, priority_req
// out      source     out_valid/out_stall status, served_id, served_priority, last
//
// An insert yields one transaction on out. A drain of N entries yields N
// transactions, one per cycle while out does not stall, set by the left shift
// of the cell chain; the in side stalls until the last one is loaded.
// Reset (rst, synchronous) empties the queue and the output register only.
// A stall on out holds the output register and, through it, the in side.
module stable_sorted_priority_queue #(
  parameter int QUEUE_DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [sspq_pkg::ID_W-1:0]   ticket_id,
  input  logic [sspq_pkg::PRIO_W-1:0] priority_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [sspq_pkg::ID_W-1:0]   served_id,
  output logic [sspq_pkg::PRIO_W-1:0] served_priority,
  output logic                      last
);
  import sspq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] fill_count;
  logic             draining;

  cell_ctl_t ctl;
  entry_t    ent       [QUEUE_DEPTH];
  logic      take      [QUEUE_DEPTH];
  entry_t    left_ent  [QUEUE_DEPTH];
  logic      left_take [QUEUE_DEPTH];
  entry_t    right_ent [QUEUE_DEPTH];
  logic      occupied  [QUEUE_DEPTH];

  logic out_load;
  logic accept;
  logic is_full;
  logic is_empty;
  logic do_insert;
  logic pop;

  // Output register frees when empty or being taken this cycle.
  assign out_load  = !out_valid || !out_stall;
  assign in_stall  = draining || !out_load;
  assign accept    = in_valid && !in_stall;
  assign is_full   = (fill_count == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (fill_count == '0);
  assign do_insert = accept && (command == CMD_INSERT) && !is_full;
  // First pop comes with the drain transaction itself; the rest while draining.
  assign pop = (accept && (command == CMD_DRAIN) && !is_empty) || (draining && out_load);

  assign ctl.insert     = do_insert;
  assign ctl.pop        = pop;
  assign ctl.fresh.id   = ticket_id;
  assign ctl.fresh.prio = priority_req;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_chain
    assign occupied[i] = (CNT_W'(i) < fill_count);

    if (i == 0) begin : g_head
      assign left_ent[i]  = '0;
      assign left_take[i] = 1'b0;
    end else begin : g_body
      assign left_ent[i]  = ent[i-1];
      assign left_take[i] = take[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent[i] = '0;
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end

    sspq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occupied[i]),
      .left_ent  (left_ent[i]),
      .left_take (left_take[i]),
      .right_ent (right_ent[i]),
      .ent       (ent[i]),
      .take      (take[i])
    );
  end

  // Track occupancy; insert and pop never fall in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      draining   <= 1'b0;
    end else begin
      if (do_insert) begin
        fill_count <= fill_count + CNT_W'(1);
      end else if (pop) begin
        fill_count <= fill_count - CNT_W'(1);
      end
      if (pop) begin
        draining <= (fill_count != CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= accept || draining;
    end
  end

  // Load the result payload; hold it while out stalls.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (pop) begin
        status          <= ST_SERVED;
        served_id       <= ent[0].id;
        served_priority <= ent[0].prio;
        last            <= (fill_count == CNT_W'(1));
      end else if (accept) begin
        served_id       <= '0;
        served_priority <= '0;
        last            <= 1'b1;
        if (command == CMD_DRAIN) begin
          status <= ST_EMPTY;
        end else if (is_full) begin
          status <= ST_FULL;
        end else begin
          status <= ST_INSERTED;
        end
      end
    end
  end

endmodule
